### hdl/fpcc_pkg.sv
// Shared types and constants for the frustum point and cube cull test.
// Used by the plane cells and the top level.
package fpcc_pkg;

    // Six planes: near, far, left, right, top, bottom.
    localparam int NUM_PLANES = 6;
    localparam int CFG_IDX_W  = $clog2(NUM_PLANES);
    localparam int PLANE_W    = 64;

    localparam int COORD_W = 16;
    localparam int HALF_W  = 15;
    localparam int COEF_W  = 16;
    localparam int ABS_W   = COEF_W + 1;
    localparam int PROD_W  = 32;
    // Width of the plane value in Q.22 with a cube term added; always large
    // enough for three coefficient products, d scaled by 2^14 and the cube term.
    localparam int SUM_W   = 35;
    localparam int D_SHIFT = 14;

    // One request as it travels down the row of plane cells.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [HALF_W-1:0]  h;
        logic                      in_view;
    } item_t;

    // Magnitude of a signed coefficient, one bit wider so that the most
    // negative code keeps its value.
    function automatic logic [ABS_W-1:0] coef_abs(input logic signed [COEF_W-1:0] v);
        logic [ABS_W-1:0] ext;
        begin
            ext = ABS_W'(v);
            if (v[COEF_W-1])
            begin
                ext = ABS_W'(0) - ext;
            end
            coef_abs = ext;
        end
    endfunction

endpackage

### hdl/fpcc_cell.sv
// One plane cell of the cull test row: holds one plane and tests each request
// against it over two pipeline stages. Depends on fpcc_pkg.
module fpcc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          ld,
    input  logic [fpcc_pkg::PLANE_W-1:0]  ld_data,
    input  logic                          vld_i,
    input  fpcc_pkg::item_t               item_i,
    output logic                          vld_o,
    output fpcc_pkg::item_t               item_o
);

    logic [fpcc_pkg::PLANE_W-1:0] plane_reg;
    logic [fpcc_pkg::ABS_W-1:0]   hsum_reg;
    logic [fpcc_pkg::ABS_W-1:0]   hsum_next;

    logic signed [fpcc_pkg::COEF_W-1:0] coef_a;
    logic signed [fpcc_pkg::COEF_W-1:0] coef_b;
    logic signed [fpcc_pkg::COEF_W-1:0] coef_c;
    logic signed [fpcc_pkg::COEF_W-1:0] coef_d;

    logic                               s1_vld_reg;
    fpcc_pkg::item_t                    s1_item_reg;
    logic signed [fpcc_pkg::PROD_W-1:0] pa_reg;
    logic signed [fpcc_pkg::PROD_W-1:0] pb_reg;
    logic signed [fpcc_pkg::PROD_W-1:0] pc_reg;
    logic        [fpcc_pkg::PROD_W-1:0] ph_reg;
    logic signed [fpcc_pkg::PROD_W-1:0] pa_next;
    logic signed [fpcc_pkg::PROD_W-1:0] pb_next;
    logic signed [fpcc_pkg::PROD_W-1:0] pc_next;
    logic        [fpcc_pkg::PROD_W-1:0] ph_next;

    logic signed [fpcc_pkg::SUM_W-1:0] value;
    logic                              s2_vld_reg;
    fpcc_pkg::item_t                   s2_item_reg;
    fpcc_pkg::item_t                   s2_item_next;

    assign coef_a = $signed(plane_reg[15:0]);
    assign coef_b = $signed(plane_reg[31:16]);
    assign coef_c = $signed(plane_reg[47:32]);
    assign coef_d = $signed(plane_reg[63:48]);

    // The sum of coefficient magnitudes is taken once, when the plane is written.
    always_comb
    begin
        hsum_next = fpcc_pkg::coef_abs($signed(ld_data[15:0]))
                  + fpcc_pkg::coef_abs($signed(ld_data[31:16]))
                  + fpcc_pkg::coef_abs($signed(ld_data[47:32]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            hsum_reg  <= '0;
        end
        else if (ld)
        begin
            plane_reg <= ld_data;
            hsum_reg  <= hsum_next;
        end
    end

    // Stage one: the three coordinate products and the cube term. The largest
    // corner value of a cube is its center value plus (|a|+|b|+|c|) * h.
    always_comb
    begin
        pa_next = coef_a * item_i.x;
        pb_next = coef_b * item_i.y;
        pc_next = coef_c * item_i.z;
        ph_next = fpcc_pkg::PROD_W'(hsum_reg) * fpcc_pkg::PROD_W'(item_i.h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= vld_i;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= item_i;
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            pc_reg      <= pc_next;
            ph_reg      <= ph_next;
            s2_item_reg <= s2_item_next;
        end
    end

    // Stage two: add up and test the sign. Zero counts as not negative.
    always_comb
    begin
        value = fpcc_pkg::SUM_W'(pa_reg) + fpcc_pkg::SUM_W'(pb_reg)
              + fpcc_pkg::SUM_W'(pc_reg)
              + (fpcc_pkg::SUM_W'(coef_d) <<< fpcc_pkg::D_SHIFT)
              + $signed(fpcc_pkg::SUM_W'(ph_reg));
        s2_item_next         = s1_item_reg;
        s2_item_next.in_view = s1_item_reg.in_view & ~value[fpcc_pkg::SUM_W-1];
    end

    assign vld_o  = s2_vld_reg;
    assign item_o = s2_item_reg;

endmodule

### hdl/frustum_point_cube_cull_test.sv
// Top level of the frustum cull test: a row of six plane cells and an output
// register. Depends on fpcc_pkg and fpcc_cell.
//
// The block tests a point or an axis-aligned cube against six frustum planes
// written through the configuration port (index 0 near, 1 far, 2 left,
// 3 right, 4 top, 5 bottom; each 64-bit word packs a, b, c as signed Q2.14 in
// bits 47:0 and d as signed Q8.8 in bits 63:48; writes to indexes 6 and 7 are
// dropped). It takes one request per clock while req_stall is low and returns
// one result per request in order: each of the six plane cells spends two
// pipeline stages on a request (the products, then the sum and sign test),
// and the output register adds one.
// A point is inside when no plane value is negative; a cube is culled when
// its largest corner value for some plane is negative, which equals the case
// where all eight corners are negative. All arithmetic is exact. The whole
// row advances together whenever the output register is empty or its result
// is being taken, so req_stall is high only while a result waits stalled.
// Planes must be written only while no requests are in flight.
module frustum_point_cube_cull_test (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [fpcc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [fpcc_pkg::PLANE_W-1:0]    cfg_wdata,

    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            req_type,
    input  logic signed [15:0]              pos_x,
    input  logic signed [15:0]              pos_y,
    input  logic signed [15:0]              pos_z,
    input  logic [14:0]                     half_size,

    output logic                            res_valid,
    input  logic                            res_stall,
    output logic                            inside_res
);

    logic                   en;
    logic                   vld  [fpcc_pkg::NUM_PLANES+1];
    fpcc_pkg::item_t        item [fpcc_pkg::NUM_PLANES+1];
    logic                   res_valid_reg;
    logic                   inside_res_reg;

    // The row moves as one; the output register parts it from the consumer.
    assign en        = !res_valid_reg || !res_stall;
    assign req_stall = !en;

    // A point request enters as a cube of size zero, so one datapath serves both.
    always_comb
    begin
        vld[0]          = req_valid;
        item[0].x       = pos_x;
        item[0].y       = pos_y;
        item[0].z       = pos_z;
        item[0].h       = req_type ? half_size : '0;
        item[0].in_view = 1'b1;
    end

    for (genvar i = 0; i < fpcc_pkg::NUM_PLANES; i++)
    begin : g_cell
        logic ld;

        assign ld = cfg_we && (cfg_idx == fpcc_pkg::CFG_IDX_W'(i));

        fpcc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ld      (ld),
            .ld_data (cfg_wdata),
            .vld_i   (vld[i]),
            .item_i  (item[i]),
            .vld_o   (vld[i+1]),
            .item_o  (item[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= vld[fpcc_pkg::NUM_PLANES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_res_reg <= item[fpcc_pkg::NUM_PLANES].in_view;
        end
    end

    assign res_valid  = res_valid_reg;
    assign inside_res = inside_res_reg;

endmodule

### hdl/fpcc_chk.sv
// Port checker for the frustum cull test, bound to the top level.
// Depends on frustum_point_cube_cull_test.
module fpcc_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  logic                            inside_res
);

    logic       cfg_seen_reg;
    logic [4:0] pend_reg;
    logic [4:0] pend_next;
    logic       req_acc;
    logic       res_acc;

    assign req_acc = req_valid && !req_stall;
    assign res_acc = res_valid && !res_stall;

    always_comb
    begin
        pend_next = pend_reg + 5'(req_acc) - 5'(res_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_seen_reg <= 1'b0;
            pend_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_seen_reg <= 1'b1;
            end
            pend_reg <= pend_next;
        end
    end

    // A waiting result stays offered and unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(inside_res))
        else $error("stalled result changed");

    // Every result belongs to an earlier accepted request.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 5'd0)
        else $error("result without a request");

    // Requests are held back only while a result waits stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("request stalled with no waiting result");

    // With all planes still cleared by reset, nothing can be culled.
    a_reset_planes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !cfg_seen_reg |-> inside_res)
        else $error("culled against cleared planes");

endmodule

bind frustum_point_cube_cull_test fpcc_chk u_fpcc_chk (.*);
